>>> hdl/bgc_pkg.sv
// Shared types, constants and register map of the button gesture classifier.
package bgc_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 8;

    localparam int DEBOUNCE_W = 8;
    localparam int TICKS_W    = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd25;
    localparam logic [TICKS_W-1:0]    LONG_RST     = 16'd3000;
    localparam logic [TICKS_W-1:0]    WINDOW_RST   = 16'd500;
    localparam logic [TICKS_W-1:0]    BLINK_RST    = 16'd500;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_WINDOW   = 2'd2;
    localparam logic [1:0] REG_BLINK    = 2'd3;

    typedef enum logic [2:0] {
        CODE_ONE        = 3'd0,
        CODE_TWO        = 3'd1,
        CODE_THREE      = 3'd2,
        CODE_SETUP_ONE  = 3'd3,
        CODE_SETUP_TWO  = 3'd4,
        CODE_MANY       = 3'd5
    } t_code;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [TICKS_W-1:0]    long_press_ticks;
        logic [TICKS_W-1:0]    window_ticks;
        logic [TICKS_W-1:0]    blink_ticks;
    } t_cfg;

    typedef struct packed {
        logic  led_b;
        logic  led_a;
        logic  setup_active;
        t_code decision_code;
        logic  decision_valid;
    } t_result;

endpackage

>>> hdl/bgc_cfg.sv
// APB register file holding the four timing registers.
module bgc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bgc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bgc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bgc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output bgc_pkg::t_cfg                      o_cfg
);

    bgc_pkg::t_cfg r_cfg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bgc_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= bgc_pkg::DEBOUNCE_RST;
            r_cfg.long_press_ticks <= bgc_pkg::LONG_RST;
            r_cfg.window_ticks     <= bgc_pkg::WINDOW_RST;
            r_cfg.blink_ticks      <= bgc_pkg::BLINK_RST;
        end else if (wr_en) begin
            case (reg_idx)
                bgc_pkg::REG_DEBOUNCE:
                    r_cfg.debounce_ticks   <= pwdata[bgc_pkg::DEBOUNCE_W-1:0];
                bgc_pkg::REG_LONG:
                    r_cfg.long_press_ticks <= pwdata[bgc_pkg::TICKS_W-1:0];
                bgc_pkg::REG_WINDOW:
                    r_cfg.window_ticks     <= pwdata[bgc_pkg::TICKS_W-1:0];
                bgc_pkg::REG_BLINK:
                    r_cfg.blink_ticks      <= pwdata[bgc_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bgc_pkg::REG_DEBOUNCE:
                prdata = bgc_pkg::APB_DATA_W'(r_cfg.debounce_ticks);
            bgc_pkg::REG_LONG:
                prdata = bgc_pkg::APB_DATA_W'(r_cfg.long_press_ticks);
            bgc_pkg::REG_WINDOW:
                prdata = bgc_pkg::APB_DATA_W'(r_cfg.window_ticks);
            bgc_pkg::REG_BLINK:
                prdata = bgc_pkg::APB_DATA_W'(r_cfg.blink_ticks);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> hdl/bgc_core.sv
// Gesture state registers and the one-tick update logic.
module bgc_core #(
    parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF,
    parameter int COUNT_WIDTH = bgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bgc_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  logic             i_edge_req,
    input  logic             i_programming_busy,
    output bgc_pkg::t_result o_res
);

    localparam int CMP_W = (TIMER_WIDTH > bgc_pkg::TICKS_W) ? TIMER_WIDTH : bgc_pkg::TICKS_W;

    logic                          r_pressed,   n_pressed;
    logic                          r_lock_act,  n_lock_act;
    logic [bgc_pkg::DEBOUNCE_W-1:0] r_lock_cnt, n_lock_cnt;
    logic                          r_hold_run,  n_hold_run;
    logic [TIMER_WIDTH-1:0]        r_hold_cnt,  n_hold_cnt;
    logic                          r_win_run,   n_win_run;
    logic [TIMER_WIDTH-1:0]        r_win_cnt,   n_win_cnt;
    logic                          r_pending,   n_pending;
    logic [COUNT_WIDTH-1:0]        r_press,     n_press;
    logic                          r_setup,     n_setup;
    logic                          r_blink_run, n_blink_run;
    logic [TIMER_WIDTH-1:0]        r_blink_cnt, n_blink_cnt;
    logic [1:0]                    r_led,       n_led;

    always_comb begin
        n_pressed   = r_pressed;
        n_lock_act  = r_lock_act;
        n_lock_cnt  = r_lock_cnt;
        n_hold_run  = r_hold_run;
        n_hold_cnt  = r_hold_cnt;
        n_win_run   = r_win_run;
        n_win_cnt   = r_win_cnt;
        n_pending   = r_pending;
        n_press     = r_press;
        n_setup     = r_setup;
        n_blink_run = r_blink_run;
        n_blink_cnt = r_blink_cnt;
        n_led       = r_led;
        o_res.decision_valid = 1'b0;
        o_res.decision_code  = bgc_pkg::CODE_ONE;

        // advance running timers, saturating
        if (n_lock_act) begin
            if (n_lock_cnt != '1) n_lock_cnt = n_lock_cnt + 1'b1;
            if (n_lock_cnt >= i_cfg.debounce_ticks) begin
                n_lock_act = 1'b0;
                n_lock_cnt = '0;
            end
        end
        if (n_hold_run) begin
            if (n_hold_cnt != '1) n_hold_cnt = n_hold_cnt + 1'b1;
            if (CMP_W'(n_hold_cnt) >= CMP_W'(i_cfg.long_press_ticks)) begin
                n_hold_run = 1'b0;
                n_hold_cnt = '0;
                if (n_pressed) begin
                    n_press     = '0;
                    n_setup     = 1'b1;
                    n_blink_run = 1'b1;
                end
            end
        end
        if (n_win_run) begin
            if (n_win_cnt != '1) n_win_cnt = n_win_cnt + 1'b1;
            if (CMP_W'(n_win_cnt) >= CMP_W'(i_cfg.window_ticks)) begin
                n_win_cnt = '0;
                n_pending = 1'b1;
            end
        end
        // blink may have been started by the hold timer in this same tick
        if (n_blink_run) begin
            if (n_blink_cnt != '1) n_blink_cnt = n_blink_cnt + 1'b1;
            if (CMP_W'(n_blink_cnt) >= CMP_W'(i_cfg.blink_ticks)) begin
                n_blink_cnt = '0;
                n_led       = ~n_led;
            end
        end

        if (i_edge_req && !i_programming_busy && !n_lock_act) begin
            n_pressed = ~n_pressed;
            if (n_pressed && n_press != '1) n_press = n_press + 1'b1;
            n_lock_act  = 1'b1;
            n_lock_cnt  = '0;
            n_hold_cnt  = '0;
            n_win_cnt   = '0;
            n_blink_cnt = '0;
            if (!n_setup) n_hold_run = 1'b1;
            n_win_run = 1'b1;
        end

        if (n_pending && n_press != '0) begin
            n_pending = 1'b0;
            if (!n_pressed) begin
                o_res.decision_valid = 1'b1;
                // every decision stops all timers
                n_hold_run  = 1'b0;
                n_win_run   = 1'b0;
                n_blink_run = 1'b0;
                n_lock_act  = 1'b0;
                n_lock_cnt  = '0;
                if (n_setup) begin
                    if (n_press == COUNT_WIDTH'(1)) begin
                        o_res.decision_code = bgc_pkg::CODE_SETUP_ONE;
                        n_led   = 2'b01;
                        n_setup = 1'b0;
                    end else if (n_press == COUNT_WIDTH'(2)) begin
                        o_res.decision_code = bgc_pkg::CODE_SETUP_TWO;
                        n_led   = 2'b00;
                        n_setup = 1'b0;
                    end else begin
                        o_res.decision_code = bgc_pkg::CODE_MANY;
                        n_led     = 2'b00;
                        n_pressed = 1'b0;
                        n_press   = '0;
                    end
                end else begin
                    if (n_press == COUNT_WIDTH'(1)) begin
                        o_res.decision_code = bgc_pkg::CODE_ONE;
                        n_led = 2'b11;
                    end else if (n_press == COUNT_WIDTH'(2)) begin
                        o_res.decision_code = bgc_pkg::CODE_TWO;
                        n_led[0] = 1'b1;
                    end else if (n_press == COUNT_WIDTH'(3)) begin
                        o_res.decision_code = bgc_pkg::CODE_THREE;
                        n_led[1] = 1'b1;
                    end else begin
                        o_res.decision_code = bgc_pkg::CODE_MANY;
                        n_pressed = 1'b0;
                        n_press   = '0;
                    end
                end
            end
        end

        o_res.setup_active = n_setup;
        o_res.led_a        = n_led[0];
        o_res.led_b        = n_led[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed   <= 1'b0;
            r_lock_act  <= 1'b0;
            r_lock_cnt  <= '0;
            r_hold_run  <= 1'b0;
            r_hold_cnt  <= '0;
            r_win_run   <= 1'b0;
            r_win_cnt   <= '0;
            r_pending   <= 1'b0;
            r_press     <= '0;
            r_setup     <= 1'b0;
            r_blink_run <= 1'b0;
            r_blink_cnt <= '0;
            r_led       <= 2'b00;
        end else if (i_step) begin
            r_pressed   <= n_pressed;
            r_lock_act  <= n_lock_act;
            r_lock_cnt  <= n_lock_cnt;
            r_hold_run  <= n_hold_run;
            r_hold_cnt  <= n_hold_cnt;
            r_win_run   <= n_win_run;
            r_win_cnt   <= n_win_cnt;
            r_pending   <= n_pending;
            r_press     <= n_press;
            r_setup     <= n_setup;
            r_blink_run <= n_blink_run;
            r_blink_cnt <= n_blink_cnt;
            r_led       <= n_led;
        end
    end

    a_hold_outside_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_setup |-> !r_hold_run)
        else $error("long-press timer running in setup mode");

    a_blink_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_run |-> r_setup)
        else $error("blink running outside setup mode");

    a_lock_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lock_act |-> r_lock_cnt == '0)
        else $error("lockout count left over after lockout ended");

    a_hold_stops_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_press) && $stable(r_setup))
        else $error("gesture state changed without an accepted beat");

endmodule

>>> hdl/button_gesture_classifier.sv
// Button gesture classifier: debounce, multi-click counting and long press.
//
// Input stream: one beat per tick. tdata bit 0 edge_req, bit 1 programming_busy.
// Output stream: one beat for every input beat, carrying the decision and the
// setup/LED levels after that tick. tdata bits from the lowest: decision_valid,
// decision_code[2:0], setup_active, led_a, led_b, one zero pad bit.
// Timing registers sit behind the APB port (debounce, long press, window, blink
// at byte addresses 0x0, 0x4, 0x8, 0xC); write them only while the stream is idle.
//
// An accepted input beat becomes its output beat in the next cycle. One beat is
// accepted every cycle while the receiver keeps taking output beats: the whole
// tick update is a single pass of counters and compares between the state
// registers and the output register, and the output register frees itself in
// the cycle its beat is taken. When the receiver stalls, the held output beat
// stays and input is accepted again as soon as the output register drains.
// Synchronous reset clears all gesture state, empties the output register and
// loads the register defaults (25, 3000, 500, 500 ticks).
module button_gesture_classifier #(
    parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF,
    parameter int COUNT_WIDTH = bgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // edge_req, programming_busy
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // decision_valid, decision_code[2:0], setup_active, led_a, led_b
    output logic [7:0]                     o_m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bgc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bgc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bgc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    bgc_pkg::t_cfg    cfg;
    bgc_pkg::t_result res;
    bgc_pkg::t_result r_out;
    logic             r_out_valid;
    logic             in_beat;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

    bgc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bgc_core #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_step             (in_beat),
        .i_edge_req         (i_s_axis_tdata[0]),
        .i_programming_busy (i_s_axis_tdata[1]),
        .o_res              (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out <= res;
        end
    end

    a_beat_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_m_axis_tvalid)
        else $error("accepted beat produced no output beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !in_beat)
        else $error("input accepted over a stalled output beat");

    a_code_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !r_out.decision_valid |-> r_out.decision_code == bgc_pkg::CODE_ONE)
        else $error("decision code set without a decision");

endmodule

>>> bench/bgc_gesture_checker.sv
`timescale 1ns / 1ps
// Tick predictor and result checker for the button gesture classifier streams.
module bgc_gesture_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [7:0]                     i_in_data,   // edge_req, programming_busy
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    // decision_valid, decision_code[2:0], setup_active, led_a, led_b
    input  logic [7:0]                     i_out_data,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [bgc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [bgc_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_mismatches,
    output int                             o_due
);

    logic [bgc_pkg::DEBOUNCE_W-1:0] debounce_cfg;
    logic [bgc_pkg::TICKS_W-1:0]    long_cfg, window_cfg, blink_cfg;

    logic                           pressed, lockout_on, hold_on, window_on;
    logic                           check_due, setup_on, blink_on;
    logic [bgc_pkg::DEBOUNCE_W-1:0] lockout_cnt;
    logic [bgc_pkg::TICKS_W-1:0]    hold_cnt, window_cnt, blink_cnt;
    logic [bgc_pkg::COUNT_WIDTH_DEF-1:0] press_cnt;
    logic [1:0]                     leds;   // bit 0 led_a, bit 1 led_b

    bgc_pkg::t_result      due_results[$];
    int                    out_beats;

    initial begin
        o_mismatches = 0;
        o_due        = 0;
        out_beats    = 0;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at output beat %0d: got %0d, expected %0d",
                 field, out_beats, got, want);
        o_mismatches++;
    endtask

    task automatic clear_button();
        pressed     = 1'b0;
        lockout_on  = 1'b0;
        lockout_cnt = '0;
        press_cnt   = '0;
    endtask

    // One tick: timers first, then the edge, then the decision.
    task automatic advance_tick(input logic pin_edge, input logic busy,
                                output bgc_pkg::t_result res);
        res = '0;
        if (lockout_on) begin
            if (lockout_cnt != '1) lockout_cnt++;
            if (lockout_cnt >= debounce_cfg) begin
                lockout_on  = 1'b0;
                lockout_cnt = '0;
            end
        end
        if (hold_on) begin
            if (hold_cnt != '1) hold_cnt++;
            if (hold_cnt >= long_cfg) begin
                hold_on  = 1'b0;
                hold_cnt = '0;
                if (pressed) begin
                    press_cnt = '0;
                    setup_on  = 1'b1;
                    blink_on  = 1'b1;
                end
            end
        end
        if (window_on) begin
            if (window_cnt != '1) window_cnt++;
            if (window_cnt >= window_cfg) begin
                window_cnt = '0;
                check_due  = 1'b1;
            end
        end
        if (blink_on) begin
            if (blink_cnt != '1) blink_cnt++;
            if (blink_cnt >= blink_cfg) begin
                blink_cnt = '0;
                leds      = ~leds;
            end
        end

        if (pin_edge && !busy && !lockout_on) begin
            pressed = ~pressed;
            if (pressed && press_cnt != '1) press_cnt++;
            lockout_on  = 1'b1;
            lockout_cnt = '0;
            hold_cnt    = '0;
            window_cnt  = '0;
            blink_cnt   = '0;
            if (!setup_on) hold_on = 1'b1;
            window_on = 1'b1;
        end

        if (check_due && press_cnt != 0) begin
            check_due = 1'b0;
            if (!pressed) begin
                res.decision_valid = 1'b1;
                if (setup_on) begin
                    if (press_cnt == 1) begin
                        res.decision_code = bgc_pkg::CODE_SETUP_ONE;
                        leds     = 2'b01;
                        setup_on = 1'b0;
                    end else if (press_cnt == 2) begin
                        res.decision_code = bgc_pkg::CODE_SETUP_TWO;
                        leds     = 2'b00;
                        setup_on = 1'b0;
                    end else begin
                        res.decision_code = bgc_pkg::CODE_MANY;
                        leds = 2'b00;
                        clear_button();
                    end
                end else begin
                    if (press_cnt == 1) begin
                        res.decision_code = bgc_pkg::CODE_ONE;
                        leds = 2'b11;
                    end else if (press_cnt == 2) begin
                        res.decision_code = bgc_pkg::CODE_TWO;
                        leds[0] = 1'b1;
                    end else if (press_cnt == 3) begin
                        res.decision_code = bgc_pkg::CODE_THREE;
                        leds[1] = 1'b1;
                    end else begin
                        res.decision_code = bgc_pkg::CODE_MANY;
                        clear_button();
                    end
                end
                // a decision stops every timer, the lockout included
                hold_on     = 1'b0;
                window_on   = 1'b0;
                blink_on    = 1'b0;
                lockout_on  = 1'b0;
                lockout_cnt = '0;
            end
        end
        res.setup_active = setup_on;
        res.led_a        = leds[0];
        res.led_b        = leds[1];
    endtask

    always @(posedge i_clk) begin : watch
        bgc_pkg::t_result want, got, fresh;
        if (!i_rst_n) begin
            debounce_cfg = bgc_pkg::DEBOUNCE_RST;
            long_cfg     = bgc_pkg::LONG_RST;
            window_cfg   = bgc_pkg::WINDOW_RST;
            blink_cfg    = bgc_pkg::BLINK_RST;
            pressed      = 1'b0;
            lockout_on   = 1'b0;
            hold_on      = 1'b0;
            window_on    = 1'b0;
            check_due    = 1'b0;
            setup_on     = 1'b0;
            blink_on     = 1'b0;
            lockout_cnt  = '0;
            hold_cnt     = '0;
            window_cnt   = '0;
            blink_cnt    = '0;
            press_cnt    = '0;
            leds         = 2'b00;
            due_results.delete();
        end else begin
            // compare before predicting: a beat leaving now belongs to an older tick
            if (i_out_valid && i_out_ready) begin
                got = bgc_pkg::t_result'(i_out_data[6:0]);
                if (due_results.size() == 0) begin
                    report_mismatch("beat with nothing due", int'(i_out_data), -1);
                end else begin
                    want = due_results.pop_front();
                    if (got.decision_valid !== want.decision_valid)
                        report_mismatch("decision_valid", int'(got.decision_valid),
                                        int'(want.decision_valid));
                    if (got.decision_code !== want.decision_code)
                        report_mismatch("decision_code", int'(got.decision_code),
                                        int'(want.decision_code));
                    if (got.setup_active !== want.setup_active)
                        report_mismatch("setup_active", int'(got.setup_active),
                                        int'(want.setup_active));
                    if (got.led_a !== want.led_a)
                        report_mismatch("led_a", int'(got.led_a), int'(want.led_a));
                    if (got.led_b !== want.led_b)
                        report_mismatch("led_b", int'(got.led_b), int'(want.led_b));
                    if (i_out_data[7] !== 1'b0)
                        report_mismatch("pad bit", int'(i_out_data[7]), 0);
                end
                out_beats++;
            end
            if (i_in_valid && i_in_ready) begin
                advance_tick(i_in_data[0], i_in_data[1], fresh);
                due_results.push_back(fresh);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    bgc_pkg::REG_DEBOUNCE:
                        debounce_cfg = i_pwdata[bgc_pkg::DEBOUNCE_W-1:0];
                    bgc_pkg::REG_LONG:
                        long_cfg     = i_pwdata[bgc_pkg::TICKS_W-1:0];
                    bgc_pkg::REG_WINDOW:
                        window_cfg   = i_pwdata[bgc_pkg::TICKS_W-1:0];
                    bgc_pkg::REG_BLINK:
                        blink_cfg    = i_pwdata[bgc_pkg::TICKS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_due = due_results.size();
    end

endmodule

>>> bench/tb_button_gesture_classifier.sv
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the button gesture classifier.
module tb_button_gesture_classifier;

    localparam int CYCLE_LIMIT = 400000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [7:0]                     in_data   = 8'd0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     out_data;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [bgc_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [bgc_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic [bgc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int mismatches;
    int due;
    int cycles       = 0;
    int ticks_sent   = 0;
    bit calm         = 1'b0;
    bit holdoff_go   = 1'b0;
    bit holdoff_done = 1'b0;
    int holdoff_left = 0;

    int cur_deb  = int'(bgc_pkg::DEBOUNCE_RST);
    int cur_long = int'(bgc_pkg::LONG_RST);
    int cur_win  = int'(bgc_pkg::WINDOW_RST);

    button_gesture_classifier uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    bgc_gesture_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_due        (due)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request, none while calm.
    always @(negedge clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else if (holdoff_go && !holdoff_done) begin
            holdoff_done = 1'b1;
            holdoff_left = 80;
            out_ready <= 1'b0;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 37);
        end
    end

    task automatic send_tick(input logic pin_edge, input logic busy);
        while (!calm && $urandom_range(99) < 37) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= {6'd0, busy, pin_edge};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic send_idle(input int n);
        repeat (n) send_tick(1'b0, $urandom_range(3) == 0);
    endtask

    task automatic send_quiet(input int n);
        repeat (n) send_tick(1'b0, 1'b0);
    endtask

    // Hold the sender until every expected beat has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int deb, input int long_t, input int win, input int blink);
        apb_write(bgc_pkg::REG_DEBOUNCE, deb);
        apb_write(bgc_pkg::REG_LONG, long_t);
        apb_write(bgc_pkg::REG_WINDOW, win);
        apb_write(bgc_pkg::REG_BLINK, blink);
        cur_deb  = deb;
        cur_long = long_t;
        cur_win  = win;
    endtask

    // Directed helpers tuned for debounce 2, window 3, long press 6.
    task automatic click_run(input int n);
        repeat (n) begin
            send_tick(1'b1, 1'b0);
            send_quiet(1);
            send_tick(1'b1, 1'b0);
            send_quiet(1);
        end
        send_quiet(4);
    endtask

    task automatic hold_long();
        send_tick(1'b1, 1'b0);
        send_quiet(8);
        send_tick(1'b1, 1'b0);
        send_quiet(4);
    endtask

    // One random gesture: clicks, an optional long first press, or pin noise.
    task automatic gesture();
        int pick, presses, hold;
        bit long_first;
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(3, 15))
                send_tick(1'($urandom_range(1)), $urandom_range(3) == 0);
        end else begin
            presses    = (pick >= 90) ? $urandom_range(4, 9) : $urandom_range(1, 4);
            long_first = ($urandom_range(99) < 25);
            for (int k = 0; k < presses; k++) begin
                send_tick(1'b1, $urandom_range(19) == 0);
                hold = (long_first && k == 0) ? cur_long + $urandom_range(0, 3)
                                              : $urandom_range(0, cur_deb + 2);
                send_idle(hold);
                send_tick(1'b1, 1'b0);
                send_idle($urandom_range(0, cur_deb + cur_win / 2));
            end
            send_idle($urandom_range(cur_win, 2 * cur_win + 2));
        end
    endtask

    task automatic run_gestures(input int budget);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < budget) gesture();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults straight out of reset: only the first edge that is not busy gets past the lockout
        repeat (20) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        drain();

        set_config(2, 6, 3, 2);
        click_run(1);                   // one
        click_run(1);                   // two, count kept
        click_run(1);                   // three
        click_run(1);                   // too many, count cleared
        send_tick(1'b1, 1'b1);          // busy: edge dropped
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);          // inside lockout: dropped
        send_quiet(2);
        send_tick(1'b1, 1'b0);
        send_quiet(5);
        hold_long();                    // enter setup
        click_run(1);                   // setup one
        hold_long();
        click_run(2);                   // setup two
        hold_long();
        click_run(3);                   // too many in setup, setup kept
        click_run(1);
        drain();

        // saturate the press count: an edge on every tick with a one-tick lockout
        set_config(1, 65535, 65535, 65535);
        calm = 1'b1;
        repeat (520) send_tick(1'b1, 1'b0);
        drain();
        apb_write(bgc_pkg::REG_WINDOW, 1);
        cur_win = 1;
        send_quiet(3);
        drain();

        set_config(255, 65535, 65535, 65535);
        repeat (20) send_tick(1'($urandom_range(1)), 1'b0);
        drain();
        calm = 1'b0;

        set_config(1, 1, 1, 1);
        run_gestures(20);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            set_config($urandom_range(1, 4), $urandom_range(4, 40),
                       $urandom_range(2, 15), $urandom_range(1, 8));
            if (phase == 0) holdoff_go = 1'b1;
            run_gestures(20);
            drain();
        end

        repeat (4) @(negedge clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bgc_pkg.sv
hdl/bgc_cfg.sv
hdl/bgc_core.sv
hdl/button_gesture_classifier.sv
bench/bgc_gesture_checker.sv
bench/tb_button_gesture_classifier.sv
